/* rtl/assert_macros.svh */
// Assertion macros shared by the time base RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define CCB_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define CCB_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CCB_ASSERT(name, clk, rstn, prop)
`define CCB_NEVER(name, clk, rstn, cond)
`endif
`endif

/* rtl/ccb_pkg.sv */
// Shared widths, register indexes, reset values and control structs of the
// cycle count time base. No dependencies.
`default_nettype none

package ccb_pkg;

  localparam int unsigned TicksW   = 32;
  localparam int unsigned BaseW    = 64;
  localparam int unsigned PerWrapW = 33;
  localparam int unsigned UsW      = 10;
  localparam int unsigned MsW      = 20;
  localparam int unsigned DivdW    = 33;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 33;

  localparam logic OP_WRAP = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_CYC_US  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CYC_MS  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_US_WRAP = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_US_REM  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MS_WRAP = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MS_REM  = 3'd5;

  localparam logic [UsW-1:0]      CYC_US_RST  = 10'd48;
  localparam logic [MsW-1:0]      CYC_MS_RST  = 20'd48000;
  localparam logic [PerWrapW-1:0] US_WRAP_RST = 33'd89478485;
  localparam logic [UsW-1:0]      US_REM_RST  = 10'd16;
  localparam logic [PerWrapW-1:0] MS_WRAP_RST = 33'd89478;
  localparam logic [MsW-1:0]      MS_REM_RST  = 20'd23296;

  typedef struct packed {
    logic capture;     // latch a read word
    logic wrap_apply;  // fold one wrap into the stored bases
    logic fold_load;   // load the working base and leftover
    logic div_start;   // launch both dividers
    logic out_load;    // write the result register
  } ccb_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } ccb_sts_t;

endpackage

`default_nettype wire

/* rtl/cycle_count_time_base.sv */
// Top level of the cycle count time base: microsecond and millisecond clocks
// for a free-running 32-bit cycle counter. Uses ccb_pkg, ccb_ctrl and ccb_dp.
//   Input channel (in_valid_i / in_stall_o) carries one word per event:
//   op_i low is a counter wrap, op_i high is a time read with the counter
//   value on tick_count_i and the wrap flag on wrap_pending_i.
//   A wrap word updates both bases at the edge it is accepted and produces
//   no result; the next word can follow in the very next cycle.
//   A read word produces one result word on the output channel
//   (out_valid_o / out_stall_i) with micros_now_o and millis_now_o.
//   A read word passes through the fold state (fold a pending wrap), the
//   start state (load the dividers) and the divide state, where the two
//   bit-serial dividers give one quotient bit per cycle over a 33-bit
//   dividend; the result register is written once the dividers are done and
//   it is free. A new word is taken in the cycle after that load, so a read is finished before the next word is taken.
//   The result register decouples the sides: a stalled result holds while
//   the next word is accepted and worked on; only the final load waits.
//   Configuration (cfg_valid_i / cfg_ready_o) is always ready and writes
//   one register per word by index; write it only while the block is idle.
//   Reset clears both bases and leftovers and loads the default rates for
//   a 48 MHz clock.
`default_nettype none

module cycle_count_time_base import ccb_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // Configuration write channel.
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,

  // Event input channel.
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic                op_i,
  input  wire logic [TicksW-1:0]   tick_count_i,
  input  wire logic                wrap_pending_i,

  // Result output channel.
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [31:0]         micros_now_o,
  output      logic [63:0]         millis_now_o
);

  ccb_cmd_t cmd;
  ccb_sts_t sts;
  logic     cfg_we;

  // The port is always open; the block does not hold register writes off
  // while the datapath is busy.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  ccb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .op_i,
    .in_stall_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  ccb_dp u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i       (cfg_we),
    .cfg_index_i,
    .cfg_data_i,
    .tick_count_i,
    .wrap_pending_i,
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i,
    .out_valid_o,
    .micros_now_o,
    .millis_now_o
  );

endmodule

`default_nettype wire

/* rtl/ccb_wrap.sv */
// Adds one counter wrap to a base and its leftover-cycle remainder.
// Pure combinational; uses nothing from the package.
`default_nettype none

module ccb_wrap #(
  parameter int unsigned LEFT_W = 10
) (
  input  wire logic [63:0]       base_i,
  input  wire logic [LEFT_W-1:0] left_i,
  input  wire logic [32:0]       per_wrap_i,
  input  wire logic [LEFT_W-1:0] rem_i,
  input  wire logic [LEFT_W-1:0] dvsr_i,
  output      logic [63:0]       base_o,
  output      logic [LEFT_W-1:0] left_o
);

  logic [LEFT_W:0] sum;
  logic [LEFT_W:0] diff;
  logic            carry;

  always_comb begin
    sum    = {1'b0, left_i} + {1'b0, rem_i};
    carry  = (sum >= {1'b0, dvsr_i});
    diff   = sum - {1'b0, dvsr_i};
    // Only one unit carries per wrap; the leftover keeps its low bits.
    left_o = carry ? diff[LEFT_W-1:0] : sum[LEFT_W-1:0];
    base_o = base_i + {31'b0, per_wrap_i} + {63'b0, carry};
  end

endmodule

`default_nettype wire

/* rtl/ccb_div.sv */
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Standalone; includes the assertion macros.
`default_nettype none
`include "assert_macros.svh"

module ccb_div #(
  parameter int unsigned DIVD_W = 33,
  parameter int unsigned DVSR_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIVD_W-1:0] dividend_i,
  input  wire logic [DVSR_W-1:0] dvsr_i,
  output      logic              busy_o,
  output      logic [DIVD_W-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(DIVD_W);
  localparam logic [CntW-1:0] CntLast = CntW'(DIVD_W - 1);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DVSR_W-1:0] rem_q, rem_d;
  logic [DVSR_W:0]   shifted;
  logic [DVSR_W:0]   diff;
  logic              ge;

  always_comb begin
    shifted = {rem_q, quo_q[DIVD_W-1]};
    ge      = (shifted >= {1'b0, dvsr_i});
    diff    = shifted - {1'b0, dvsr_i};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVD_W-2:0], ge};
      rem_d = ge ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

  `CCB_ASSERT(a_div_ends, clk_i, rst_ni, (busy_q && !start_i && cnt_q == CntLast) |=> !busy_q)
  `CCB_ASSERT(a_div_rem_lt, clk_i, rst_ni, (busy_q && dvsr_i != '0) |-> (rem_q < dvsr_i))

endmodule

`default_nettype wire

/* rtl/ccb_dp.sv */
// Datapath of the time base: configuration registers, bases, working copy,
// two serial dividers and the result register. Uses ccb_pkg, ccb_wrap, ccb_div.
`default_nettype none

module ccb_dp import ccb_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic [TicksW-1:0]   tick_count_i,
  input  wire logic                wrap_pending_i,
  input  wire ccb_cmd_t            cmd_i,
  output      ccb_sts_t            sts_o,
  input  wire logic                out_stall_i,
  output      logic                out_valid_o,
  output      logic [31:0]         micros_now_o,
  output      logic [63:0]         millis_now_o
);

  // Configuration.
  logic [UsW-1:0]      cyc_us_q;
  logic [MsW-1:0]      cyc_ms_q;
  logic [PerWrapW-1:0] us_wrap_q;
  logic [UsW-1:0]      us_rem_q;
  logic [PerWrapW-1:0] ms_wrap_q;
  logic [MsW-1:0]      ms_rem_q;

  // Time base state.
  logic [BaseW-1:0] us_base_q, ms_base_q;
  logic [UsW-1:0]   us_left_q;
  logic [MsW-1:0]   ms_left_q;

  // Working copy for one read.
  logic [TicksW-1:0] ticks_q;
  logic              pend_q;
  logic [BaseW-1:0]  wb_us_q, wb_ms_q;
  logic [UsW-1:0]    wl_us_q;
  logic [MsW-1:0]    wl_ms_q;

  logic             out_valid_q;
  logic [31:0]      micros_q;
  logic [63:0]      millis_q;

  logic [UsW-1:0]   dvsr_us;
  logic [MsW-1:0]   dvsr_ms;
  logic [BaseW-1:0] nb_us, nb_ms;
  logic [UsW-1:0]   nl_us;
  logic [MsW-1:0]   nl_ms;
  logic             fold;
  logic             busy_us, busy_ms;
  logic [DivdW-1:0] quo_us, quo_ms;
  logic [DivdW-1:0] divd_us, divd_ms;

  // A zero divisor register counts as one.
  assign dvsr_us = (cyc_us_q == '0) ? UsW'(1) : cyc_us_q;
  assign dvsr_ms = (cyc_ms_q == '0) ? MsW'(1) : cyc_ms_q;

  ccb_wrap #(.LEFT_W(UsW)) u_wrap_us (
    .base_i(us_base_q), .left_i(us_left_q), .per_wrap_i(us_wrap_q),
    .rem_i(us_rem_q), .dvsr_i(dvsr_us), .base_o(nb_us), .left_o(nl_us)
  );

  ccb_wrap #(.LEFT_W(MsW)) u_wrap_ms (
    .base_i(ms_base_q), .left_i(ms_left_q), .per_wrap_i(ms_wrap_q),
    .rem_i(ms_rem_q), .dvsr_i(dvsr_ms), .base_o(nb_ms), .left_o(nl_ms)
  );

  // A pending wrap is only folded in when the count has already restarted.
  assign fold = pend_q && !ticks_q[TicksW-1];

  // floor((ticks + left) / div) equals whole + floor((part + left) / div).
  assign divd_us = {1'b0, ticks_q} + {{(DivdW-UsW){1'b0}}, wl_us_q};
  assign divd_ms = {1'b0, ticks_q} + {{(DivdW-MsW){1'b0}}, wl_ms_q};

  ccb_div #(.DIVD_W(DivdW), .DVSR_W(UsW)) u_div_us (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(divd_us),
    .dvsr_i(dvsr_us), .busy_o(busy_us), .quo_o(quo_us)
  );

  ccb_div #(.DIVD_W(DivdW), .DVSR_W(MsW)) u_div_ms (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(divd_ms),
    .dvsr_i(dvsr_ms), .busy_o(busy_ms), .quo_o(quo_ms)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_us_q  <= CYC_US_RST;
      cyc_ms_q  <= CYC_MS_RST;
      us_wrap_q <= US_WRAP_RST;
      us_rem_q  <= US_REM_RST;
      ms_wrap_q <= MS_WRAP_RST;
      ms_rem_q  <= MS_REM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CYC_US:  cyc_us_q  <= cfg_data_i[UsW-1:0];
        CFG_CYC_MS:  cyc_ms_q  <= cfg_data_i[MsW-1:0];
        CFG_US_WRAP: us_wrap_q <= cfg_data_i[PerWrapW-1:0];
        CFG_US_REM:  us_rem_q  <= cfg_data_i[UsW-1:0];
        CFG_MS_WRAP: ms_wrap_q <= cfg_data_i[PerWrapW-1:0];
        CFG_MS_REM:  ms_rem_q  <= cfg_data_i[MsW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      us_base_q <= '0;
      us_left_q <= '0;
      ms_base_q <= '0;
      ms_left_q <= '0;
    end else if (cmd_i.wrap_apply) begin
      us_base_q <= nb_us;
      us_left_q <= nl_us;
      ms_base_q <= nb_ms;
      ms_left_q <= nl_ms;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ticks_q <= tick_count_i;
      pend_q  <= wrap_pending_i;
    end
    if (cmd_i.fold_load) begin
      wb_us_q <= fold ? nb_us : us_base_q;
      wl_us_q <= fold ? nl_us : us_left_q;
      wb_ms_q <= fold ? nb_ms : ms_base_q;
      wl_ms_q <= fold ? nl_ms : ms_left_q;
    end
    if (cmd_i.out_load) begin
      micros_q <= wb_us_q[31:0] + quo_us[31:0];
      millis_q <= wb_ms_q + {32'b0, quo_ms[31:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.div_busy = busy_us | busy_ms;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign micros_now_o = micros_q;
  assign millis_now_o = millis_q;

endmodule

`default_nettype wire

/* rtl/ccb_ctrl.sv */
// Controller of the time base: applies wrap words directly and sequences a read
// through fold, divider start, divide and result load. Uses ccb_pkg and the assertion macros.
`default_nettype none
`include "assert_macros.svh"

module ccb_ctrl import ccb_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     op_i,
  output      logic     in_stall_o,
  input  wire ccb_sts_t sts_i,
  output      ccb_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_START,
    ST_DIV
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_READ) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_FOLD;
          end else begin
            cmd_o.wrap_apply = 1'b1;
          end
        end
      end
      ST_FOLD: begin
        cmd_o.fold_load = 1'b1;
        state_d         = ST_START;
      end
      ST_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (!sts_i.div_busy && sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `CCB_ASSERT(a_start_busy, clk_i, rst_ni, cmd_o.div_start |=> sts_i.div_busy)
  `CCB_ASSERT(a_load_free, clk_i, rst_ni, cmd_o.out_load |-> (sts_i.out_free && !sts_i.div_busy))
  `CCB_NEVER(a_wrap_mid_read, clk_i, rst_ni, cmd_o.wrap_apply && state_q != ST_IDLE)

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for cycle_count_time_base: drives wrap and read words,
// predicts the microsecond and millisecond answers and compares every result word.
// Depends on ccb_pkg and the cycle_count_time_base RTL only.
`timescale 1ns / 1ps

module tb_top;
  import ccb_pkg::*;

  // The drain and settle waits cover one read from acceptance to its result
  // word, plus a little margin.
  localparam int unsigned DrainCycles   = 40;
  // Longest quiet stretch a correct run can show is the long output hold
  // (LongHold) or one read with both sides idling; this is several times that.
  localparam int unsigned QuietLimit    = 4000;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned WordsPerPhase = 80;
  localparam int unsigned ScriptRows    = 17;
  localparam logic [31:0] HalfRange     = 32'h8000_0000;
  localparam logic [19:0] UsLeftMask    = 20'h003FF;
  localparam logic [19:0] MsLeftMask    = 20'hFFFFF;

  typedef struct packed {
    logic [31:0] us;
    logic [63:0] ms;
  } time_word_t;

  // One row of the directed script. Rows with typed set carry an answer that
  // is plain from the reset rates; all others are left to the predictor.
  typedef struct packed {
    bit          stage;
    logic        op;
    logic [31:0] ticks;
    logic        pend;
    bit          typed;
    logic [31:0] us;
    logic [63:0] ms;
  } script_row_t;

  // Clock and reset. Every block input has a known value from time zero.
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = CFG_CYC_US;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                op_i           = OP_WRAP;
  logic [TicksW-1:0]   tick_count_i   = '0;
  logic                wrap_pending_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [31:0]         micros_now_o;
  logic [63:0]         millis_now_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cycle_count_time_base u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .tick_count_i   (tick_count_i),
    .wrap_pending_i (wrap_pending_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .micros_now_o   (micros_now_o),
    .millis_now_o   (millis_now_o)
  );

  // ---------------------------------------------------------------------------
  // Time base predictor: its own copy of the rate registers (reset defaults)
  // and of both bases with their leftover cycle counts.
  // ---------------------------------------------------------------------------
  logic [UsW-1:0]      rate_us        = CYC_US_RST;
  logic [MsW-1:0]      rate_ms        = CYC_MS_RST;
  logic [PerWrapW-1:0] us_wrap_units  = US_WRAP_RST;
  logic [UsW-1:0]      us_wrap_cycles = US_REM_RST;
  logic [PerWrapW-1:0] ms_wrap_units  = MS_WRAP_RST;
  logic [MsW-1:0]      ms_wrap_cycles = MS_REM_RST;
  logic [63:0]         us_base        = '0;
  logic [19:0]         us_left        = '0;
  logic [63:0]         ms_base        = '0;
  logic [19:0]         ms_left        = '0;

  // Answers still owed by the block, oldest first.
  time_word_t due_times[$];

  // Run statistics; mismatches is written by the checker alone.
  int unsigned mismatches    = 0;
  int unsigned words_checked = 0;
  int unsigned wraps_sent    = 0;
  int unsigned reads_sent    = 0;
  int unsigned rate_sets     = 0;

  // Idling knobs, set per phase by the stimulus process.
  int unsigned src_gap_pct   = 0;
  int unsigned sink_busy_pct = 0;
  // The stimulus process bumps hold_req_cnt to ask the receiver for one long
  // hold; the receiver tracks what it has served in hold_done_cnt.
  int unsigned hold_req_cnt  = 0;
  int unsigned hold_done_cnt = 0;
  int unsigned hold_left     = 0;

  script_row_t script [ScriptRows];

  // A rate register holding zero counts as one cycle per unit.
  function automatic logic [31:0] divisor(input logic [19:0] rate);
    return (rate == '0) ? 32'd1 : {12'd0, rate};
  endfunction

  // Adds one counter wrap to a base. At most one unit is carried per wrap,
  // so a leftover can sit above the divisor; it is kept at its state width.
  function automatic void fold_wrap(inout logic [63:0] base, inout logic [19:0] left,
                                    input logic [32:0] units, input logic [19:0] cycles,
                                    input logic [19:0] rate, input logic [19:0] mask);
    logic [31:0] r;
    r    = {12'd0, left} + {12'd0, cycles};
    base = base + {31'd0, units};
    if (r >= divisor(rate)) begin
      base = base + 64'd1;
      r    = r - divisor(rate);
    end
    left = r[19:0] & mask;
  endfunction

  // Whole units in a tick count, with the leftover cycles added to the
  // partial unit. The sum is 32 bits wide and wraps like the hardware word.
  function automatic logic [31:0] units_in(input logic [31:0] ticks,
                                           input logic [19:0] left,
                                           input logic [19:0] rate);
    logic [31:0] div;
    logic [31:0] whole;
    logic [31:0] part;
    div   = divisor(rate);
    whole = ticks / div;
    part  = ticks - whole * div;
    return whole + (part + {12'd0, left}) / div;
  endfunction

  // Applies one accepted word. A wrap updates the bases; a read folds a
  // pending wrap into local copies only, when the count is below half range.
  function automatic void predict_word(input logic op, input logic [31:0] ticks,
                                       input logic pend, output bit has,
                                       output time_word_t tw);
    logic [63:0] ub;
    logic [63:0] mb;
    logic [19:0] ul;
    logic [19:0] ml;
    logic [19:0] us_cyc;
    logic [19:0] us_rate;
    has     = 1'b0;
    tw      = '0;
    us_cyc  = {10'd0, us_wrap_cycles};
    us_rate = {10'd0, rate_us};
    if (op == OP_WRAP) begin
      fold_wrap(us_base, us_left, us_wrap_units, us_cyc, us_rate, UsLeftMask);
      fold_wrap(ms_base, ms_left, ms_wrap_units, ms_wrap_cycles, rate_ms, MsLeftMask);
    end else begin
      ub = us_base;
      ul = us_left;
      mb = ms_base;
      ml = ms_left;
      if (pend && ticks < HalfRange) begin
        fold_wrap(ub, ul, us_wrap_units, us_cyc, us_rate, UsLeftMask);
        fold_wrap(mb, ml, ms_wrap_units, ms_wrap_cycles, rate_ms, MsLeftMask);
      end
      tw.us = ub[31:0] + units_in(ticks, ul, us_rate);
      tw.ms = mb + {32'd0, units_in(ticks, ml, rate_ms)};
      has   = 1'b1;
    end
  endfunction

  function automatic void latch_rate(input logic [CfgIdxW-1:0] idx,
                                     input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_CYC_US:  rate_us        = data[UsW-1:0];
      CFG_CYC_MS:  rate_ms        = data[MsW-1:0];
      CFG_US_WRAP: us_wrap_units  = data[PerWrapW-1:0];
      CFG_US_REM:  us_wrap_cycles = data[UsW-1:0];
      CFG_MS_WRAP: ms_wrap_units  = data[PerWrapW-1:0];
      CFG_MS_REM:  ms_wrap_cycles = data[MsW-1:0];
      default: ;
    endcase
  endfunction

  // Counter values biased toward zero, the top of the range and both sides
  // of the half-range boundary that decides whether a pending wrap is folded.
  function automatic logic [31:0] pick_ticks();
    case ($urandom_range(0, 5))
      3:       return HalfRange + $urandom_range(0, 7) - 32'd4;
      4:       return $urandom_range(0, 4095);
      5:       return 32'hFFFF_FFFF - $urandom_range(0, 4095);
      default: return $urandom();
    endcase
  endfunction

  // A 33-bit per-wrap count; a third of them are shifted down to small values.
  function automatic logic [32:0] rand33();
    logic [32:0] v;
    v[31:0] = $urandom();
    v[32]   = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 2) == 0) begin
      v = v >> $urandom_range(8, 32);
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered right after a rising edge and drives with
  // nonblocking assignments, so the block sees stable inputs at the next edge.
  // ---------------------------------------------------------------------------

  // Offers one word and holds it until accepted. Valid stays high on return,
  // so back-to-back words never lower and raise it in the same step.
  task automatic send_word(input logic op, input logic [31:0] ticks, input logic pend,
                           input bit typed, input logic [31:0] us, input logic [63:0] ms);
    bit         has;
    time_word_t tw;
    if ($urandom_range(0, 99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    tick_count_i   <= ticks;
    wrap_pending_i <= pend;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(op, ticks, pend, has, tw);
    if (has) begin
      if (typed) begin
        tw.us = us;
        tw.ms = ms;
      end
      due_times.push_back(tw);
      reads_sent++;
    end else begin
      wraps_sent++;
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    latch_rate(idx, data);
  endtask

  task automatic program_rates(input logic [CfgDataW-1:0] cyc_us,
                               input logic [CfgDataW-1:0] cyc_ms,
                               input logic [CfgDataW-1:0] us_wrap,
                               input logic [CfgDataW-1:0] us_rem,
                               input logic [CfgDataW-1:0] ms_wrap,
                               input logic [CfgDataW-1:0] ms_rem);
    write_reg(CFG_CYC_US, cyc_us);
    write_reg(CFG_CYC_MS, cyc_ms);
    write_reg(CFG_US_WRAP, us_wrap);
    write_reg(CFG_US_REM, us_rem);
    write_reg(CFG_MS_WRAP, ms_wrap);
    write_reg(CFG_MS_REM, ms_rem);
    cfg_valid_i <= 1'b0;
    rate_sets++;
  endtask

  // Stops offering words and lets every owed answer arrive. A wrap leaves no
  // answer behind, so a full read latency passes before the block counts as idle.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (due_times.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stalls in random bursts, and once per request holds off for one
  // long hold so the block fills up and stalls its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req_cnt != hold_done_cnt) begin
      hold_done_cnt <= hold_req_cnt;
      hold_left     <= LongHold - 1;
      out_stall_i   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < sink_busy_pct) begin
      hold_left   <= $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Checker: each result word taken off the output is matched against the
  // oldest owed answer, field by field.
  always @(posedge clk_i) begin
    time_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_times.size() == 0) begin
        $error("result word with no read outstanding: micros_now %0d millis_now %0d",
               micros_now_o, millis_now_o);
        mismatches++;
      end else begin
        want = due_times.pop_front();
        words_checked++;
        if (micros_now_o !== want.us) begin
          $error("micros_now mismatch: expected %0d, got %0d", want.us, micros_now_o);
          mismatches++;
        end
        if (millis_now_o !== want.ms) begin
          $error("millis_now mismatch: expected %0d, got %0d", want.ms, millis_now_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    int          ph;
    int          k;
    logic        op;

    // Stage 0 runs at the reset rates from zero bases: the first reads have
    // answers that follow straight from a 48 MHz clock.
    script[0]  = '{1'b0, OP_READ, 32'h0000_0000, 1'b0, 1'b1, 32'd0, 64'd0};
    script[1]  = '{1'b0, OP_READ, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd89478485, 64'd89478};
    // Pending wrap with a small count is folded in.
    script[2]  = '{1'b0, OP_READ, 32'h0000_0000, 1'b1, 1'b1, 32'd89478485, 64'd89478};
    // Pending wrap at exactly half range is not folded.
    script[3]  = '{1'b0, OP_READ, HalfRange,     1'b1, 1'b1, 32'd44739242, 64'd44739};
    script[4]  = '{1'b0, OP_READ, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'd0, 64'd0};
    // Wraps ignore the count and the pending flag.
    script[5]  = '{1'b0, OP_WRAP, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 64'd0};
    script[6]  = '{1'b0, OP_WRAP, 32'h1234_5678, 1'b0, 1'b0, 32'd0, 64'd0};
    script[7]  = '{1'b0, OP_READ, 32'h0000_0000, 1'b0, 1'b0, 32'd0, 64'd0};
    script[8]  = '{1'b0, OP_READ, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 64'd0};
    // Stage 1 runs with zero divisors (taken as one), full per-wrap counts and
    // remainders far above the divisor, so leftovers pile up and the 32-bit
    // unit count wraps.
    script[9]  = '{1'b1, OP_WRAP, 32'h0000_0000, 1'b0, 1'b0, 32'd0, 64'd0};
    script[10] = '{1'b1, OP_READ, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0, 64'd0};
    script[11] = '{1'b1, OP_WRAP, 32'h5555_5555, 1'b1, 1'b0, 32'd0, 64'd0};
    script[12] = '{1'b1, OP_WRAP, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'd0, 64'd0};
    script[13] = '{1'b1, OP_READ, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'd0, 64'd0};
    script[14] = '{1'b1, OP_READ, HalfRange,     1'b1, 1'b0, 32'd0, 64'd0};
    script[15] = '{1'b1, OP_READ, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 64'd0};
    script[16] = '{1'b1, OP_READ, 32'h0000_0001, 1'b0, 1'b0, 32'd0, 64'd0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_gap_pct   = 25;
    sink_busy_pct = 10;
    foreach (script[i]) begin
      if (script[i].stage == 1'b0) begin
        send_word(script[i].op, script[i].ticks, script[i].pend, script[i].typed,
                  script[i].us, script[i].ms);
      end
    end
    settle_block();
    program_rates(33'd0, 33'd0, 33'h1_FFFF_FFFF, 33'h3FF, 33'h1_FFFF_FFFF, 33'hF_FFFF);
    foreach (script[i]) begin
      if (script[i].stage == 1'b1) begin
        send_word(script[i].op, script[i].ticks, script[i].pend, script[i].typed,
                  script[i].us, script[i].ms);
      end
    end

    // Random phases. Phase 1 keeps the zero-divisor rates of stage 1, then come
    // full-width divisors, divisors of one, the reset rates under a long output
    // hold, and random rates. The last phase runs with no idling at all.
    for (ph = 1; ph <= 8; ph++) begin
      if (ph > 1) begin
        settle_block();
        case (ph)
          2: program_rates(33'h3FF, 33'hF_FFFF, 33'd0, 33'h3FF, 33'd0, 33'hF_FFFF);
          3: program_rates(33'd1, 33'd1, rand33(), $urandom_range(0, 1023),
                           rand33(), $urandom_range(0, 20'hF_FFFF));
          4: program_rates(CYC_US_RST, CYC_MS_RST, US_WRAP_RST, US_REM_RST,
                           MS_WRAP_RST, MS_REM_RST);
          default: program_rates(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                               : $urandom_range(1, 64),
                                 ($urandom_range(0, 2) == 0) ? $urandom_range(0, 20'hF_FFFF)
                                                               : $urandom_range(1, 5000),
                                 rand33(), $urandom_range(0, 1023),
                                 rand33(), $urandom_range(0, 20'hF_FFFF));
        endcase
      end
      if (ph == 8) begin
        src_gap_pct   = 0;
        sink_busy_pct = 0;
      end else begin
        src_gap_pct   = 25 * $urandom_range(0, 2);
        sink_busy_pct = 10 * $urandom_range(0, 2);
      end
      // The long hold opens the reset-rate phase; a run of reads right behind
      // it fills the result register and the divider so the input stalls.
      if (ph == 4) begin
        hold_req_cnt++;
      end
      for (k = 0; k < WordsPerPhase; k++) begin
        op = ((ph == 4 && k < 12) || $urandom_range(0, 99) < 65) ? OP_READ : OP_WRAP;
        send_word(op, pick_ticks(), 1'($urandom_range(0, 1)), 1'b0, '0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (due_times.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d wrap words and %0d read words over %0d rate settings,",
             wraps_sent, reads_sent, rate_sets + 1);
    $display("  including zero and full-width divisors; %0d time words compared, %0d errors.",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
